FILE: design/oed_pkg.sv
package oed_pkg;

    // Fixed widths of the word fields.
    localparam int OP_W  = 2;
    localparam int CH_W  = 16;
    localparam int RES_W = 7;

    // Operation codes carried in the op field of an input word.
    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE       = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [CH_W-1:0] ch;
    } t_in_word;

    typedef struct packed {
        logic [RES_W-1:0] dist_res;
        logic [RES_W-1:0] len_first;
        logic [RES_W-1:0] len_second;
        logic             overflowed;
    } t_out_word;

    typedef enum logic [1:0] {
        SW_IDLE,
        SW_RUN,
        SW_DRAIN,
        SW_DONE
    } t_sweep_state;

    // Commands from the top level to the sweep sequencer.
    typedef struct packed {
        logic start;
        logic ack;
    } t_sweep_cmd;

    // Status from the sweep sequencer to the top level.
    typedef struct packed {
        logic busy;
        logic done;
    } t_sweep_stat;

endpackage

FILE: design/oed_stream_if.sv
interface oed_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/oed_char_store.sv
module oed_char_store
    import oed_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int CHAR_BITS = 16,
    localparam int IW = $clog2(MAX_LEN)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic                 i_w_sel,
    input  logic [IW-1:0]        i_w_idx,
    input  logic [CHAR_BITS-1:0] i_w_data,
    input  logic [IW-1:0]        i_a_idx,
    input  logic [IW-1:0]        i_b_idx,
    output logic [CHAR_BITS-1:0] o_a_data,
    output logic [CHAR_BITS-1:0] o_b_data
);

    // Both strings share one memory; the first index selects the string.
    logic [CHAR_BITS-1:0] r_mem [0:1][0:MAX_LEN-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_w_sel][i_w_idx] <= i_w_data;
        end
        o_a_data <= r_mem[0][i_a_idx];
        o_b_data <= r_mem[1][i_b_idx];
    end

endmodule

FILE: design/oed_row_store.sv
module oed_row_store
    import oed_pkg::*;
#(
    parameter int MAX_LEN = 64,
    localparam int IW = $clog2(MAX_LEN),
    localparam int LW = $clog2(MAX_LEN + 1)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [1:0]    i_w_row,
    input  logic [IW-1:0] i_w_col,
    input  logic [LW-1:0] i_w_data,
    input  logic [1:0]    i_rd0_row,
    input  logic [IW-1:0] i_rd0_col,
    input  logic [1:0]    i_rd1_row,
    input  logic [IW-1:0] i_rd1_col,
    output logic [LW-1:0] o_rd0_data,
    output logic [LW-1:0] o_rd1_data
);

    // Three rotating cost rows; column 0 of the table is never stored.
    logic [LW-1:0] r_mem [0:2][0:MAX_LEN-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_w_row][i_w_col] <= i_w_data;
        end
        o_rd0_data <= r_mem[i_rd0_row][i_rd0_col];
        o_rd1_data <= r_mem[i_rd1_row][i_rd1_col];
    end

endmodule

FILE: design/oed_sweep.sv
module oed_sweep
    import oed_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int CHAR_BITS = 16,
    localparam int IW = $clog2(MAX_LEN),
    localparam int LW = $clog2(MAX_LEN + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_sweep_cmd           i_cmd,
    output t_sweep_stat          o_stat,
    input  logic [LW-1:0]        i_len_a,
    input  logic [LW-1:0]        i_len_b,
    output logic [IW-1:0]        o_a_idx,
    output logic [IW-1:0]        o_b_idx,
    input  logic [CHAR_BITS-1:0] i_a_data,
    input  logic [CHAR_BITS-1:0] i_b_data,
    output logic [1:0]           o_up_row,
    output logic [IW-1:0]        o_up_col,
    output logic [1:0]           o_up2_row,
    output logic [IW-1:0]        o_up2_col,
    input  logic [LW-1:0]        i_up_data,
    input  logic [LW-1:0]        i_up2_data,
    output logic                 o_we,
    output logic [1:0]           o_w_row,
    output logic [IW-1:0]        o_w_col,
    output logic [LW-1:0]        o_w_data,
    output logic [LW-1:0]        o_dist
);

    function automatic logic [1:0] row_prev(input logic [1:0] row);
        logic [1:0] res;
        case (row)
            2'd0:    res = 2'd2;
            2'd1:    res = 2'd0;
            2'd2:    res = 2'd1;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] row_next(input logic [1:0] row);
        logic [1:0] res;
        case (row)
            2'd0:    res = 2'd1;
            2'd1:    res = 2'd2;
            2'd2:    res = 2'd0;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    t_sweep_state r_state, n_state;
    logic [LW-1:0] r_i, n_i, r_j, n_j;
    logic [1:0]    r_rcur, n_rcur;
    logic [LW-1:0] r_dist, n_dist;
    logic          w_issue;

    // Cell stage registers.
    logic                 r_dv, r_hit, w_hit;
    logic [LW-1:0]        r_di, r_dj;
    logic [1:0]           r_drow;
    logic [LW-1:0]        r_up_last, r_v_last;
    logic [CHAR_BITS-1:0] r_a_last, r_b_last;

    logic [LW-1:0] w_up, w_up_jm1, w_left, w_up2, w_v;
    logic [LW:0]   w_up1, w_left1, w_diag, w_tr1, w_m1, w_m2, w_m3;
    logic          w_cost, w_trans;

    // Issue side: addresses of the cell (r_i, r_j).
    assign o_a_idx   = IW'(r_i - LW'(1));
    assign o_b_idx   = IW'(r_j - LW'(1));
    assign o_up_row  = row_prev(r_rcur);
    assign o_up_col  = IW'(r_j - LW'(1));
    assign o_up2_row = row_next(r_rcur);
    assign o_up2_col = IW'(r_j - LW'(3));

    // Cell side: the table borders (row 0, column 0) are formed here, not stored.
    always_comb begin
        if (r_di == LW'(1)) begin
            w_up = r_dj;
        end else if (r_hit) begin
            w_up = r_v_last;
        end else begin
            w_up = i_up_data;
        end
        w_up_jm1 = (r_dj == LW'(1)) ? r_di - LW'(1) : r_up_last;
        w_left   = (r_dj == LW'(1)) ? r_di : r_v_last;
        if (r_dj == LW'(2)) begin
            w_up2 = r_di - LW'(2);
        end else if (r_di == LW'(2)) begin
            w_up2 = r_dj - LW'(2);
        end else begin
            w_up2 = i_up2_data;
        end
        w_cost  = (i_a_data != i_b_data);
        w_trans = (r_di > LW'(1)) && (r_dj > LW'(1)) &&
                  (i_a_data == r_b_last) && (r_a_last == i_b_data);
        w_up1   = {1'b0, w_up} + (LW + 1)'(1);
        w_left1 = {1'b0, w_left} + (LW + 1)'(1);
        w_diag  = {1'b0, w_up_jm1} + (LW + 1)'(w_cost);
        w_tr1   = {1'b0, w_up2} + (LW + 1)'(1);
        w_m1    = (w_up1 < w_left1) ? w_up1 : w_left1;
        w_m2    = (w_diag < w_m1) ? w_diag : w_m1;
        w_m3    = (w_trans && (w_tr1 < w_m2)) ? w_tr1 : w_m2;
        w_v     = LW'(w_m3);
    end

    assign o_we     = r_dv;
    assign o_w_row  = r_drow;
    assign o_w_col  = IW'(r_dj - LW'(1));
    assign o_w_data = w_v;

    // The cell being issued reads the entry the cell stage writes now: forward it.
    assign w_hit = w_issue && r_dv && (o_w_row == o_up_row) && (o_w_col == o_up_col);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_rcur  = r_rcur;
        n_dist  = r_dist;
        w_issue = 1'b0;
        case (r_state)
            SW_IDLE: begin
                if (i_cmd.start) begin
                    if (i_len_a == '0) begin
                        n_dist  = i_len_b;
                        n_state = SW_DONE;
                    end else if (i_len_b == '0) begin
                        n_dist  = i_len_a;
                        n_state = SW_DONE;
                    end else begin
                        n_i     = LW'(1);
                        n_j     = LW'(1);
                        n_rcur  = 2'd1;
                        n_state = SW_RUN;
                    end
                end
            end
            SW_RUN: begin
                w_issue = 1'b1;
                if (r_j == i_len_b) begin
                    n_j    = LW'(1);
                    n_i    = r_i + LW'(1);
                    n_rcur = row_next(r_rcur);
                    if (r_i == i_len_a) begin
                        n_state = SW_DRAIN;
                    end
                end else begin
                    n_j = r_j + LW'(1);
                end
            end
            SW_DRAIN: begin
                n_dist  = w_v;
                n_state = SW_DONE;
            end
            SW_DONE: begin
                if (i_cmd.ack) begin
                    n_state = SW_IDLE;
                end
            end
            default: begin
                n_state = SW_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SW_IDLE;
            r_dv    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= w_issue;
            r_hit   <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_rcur <= n_rcur;
        r_dist <= n_dist;
        if (w_issue) begin
            r_di   <= r_i;
            r_dj   <= r_j;
            r_drow <= r_rcur;
        end
        if (r_dv) begin
            r_up_last <= w_up;
            r_v_last  <= w_v;
            r_b_last  <= i_b_data;
            if (r_dj == i_len_b) begin
                r_a_last <= i_a_data;
            end
        end
    end

    assign o_stat.busy = (r_state != SW_IDLE);
    assign o_stat.done = (r_state == SW_DONE);
    assign o_dist      = r_dist;

    a_no_cell_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SW_IDLE) |-> !r_dv)
        else $error("cell stage active while the sweep is idle");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_state == SW_IDLE))
        else $error("sweep started while busy");

    a_fwd_follows_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (r_dv && $past(r_dv)))
        else $error("forwarded cost without a preceding write");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SW_DONE) |-> (r_dist <= LW'(MAX_LEN)))
        else $error("distance above string capacity");

endmodule

FILE: design/osa_edit_distance_core.sv
// Channel  Dir  Word        Fields
// i_in     in   t_in_word   op (2), ch (16)
// o_out    out  t_out_word  dist_res (7), len_first (7), len_second (7), overflowed (1)
//
// Append words (op 0 and 1) and the unused op 3 leave i_in.ready high.
// A compute word starts the row sweep over the two stored strings, which evaluates one
// table cell per cycle through the row memory. With an empty string the sweep is
// skipped and the distance is the length of the other string.
// i_in.ready is low from the compute word until its result enters the output register.
// Reset clears the lengths, the overflow flag and all control state; memories keep data.
module osa_edit_distance_core
    import oed_pkg::*;
#(
    parameter int MAX_LEN   = 64,
    parameter int CHAR_BITS = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    oed_stream_if.sink    i_in,
    oed_stream_if.source  o_out
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    // Lengths of the two stored strings and the sticky overflow flag.
    logic [LW-1:0] r_len_a, r_len_b;
    logic          r_ovf;

    // Output register; it lets the sweep finish while the sink stalls.
    logic      r_out_valid;
    t_out_word r_out_word;

    logic                 w_in_acc, w_ack;
    logic                 w_we_a, w_we_b, w_drop;
    logic                 w_cs_we, w_cs_sel;
    logic [IW-1:0]        w_cs_idx;
    logic [CHAR_BITS-1:0] w_cs_data;
    t_sweep_cmd           w_cmd;
    t_sweep_stat          w_stat;

    logic [IW-1:0]        w_a_idx, w_b_idx;
    logic [CHAR_BITS-1:0] w_a_data, w_b_data;
    logic [1:0]           w_up_row, w_up2_row, w_w_row;
    logic [IW-1:0]        w_up_col, w_up2_col, w_w_col;
    logic [LW-1:0]        w_up_data, w_up2_data, w_w_data, w_dist;
    logic                 w_row_we;

    // New words are taken only while the sweep is idle; a result waiting for the output register blocks them.
    assign i_in.ready = !w_stat.busy;
    assign w_in_acc   = i_in.valid && i_in.ready;

    // An append to a full string drops the character and marks the overflow.
    always_comb begin
        w_we_a    = w_in_acc && (i_in.data.op == OP_APPEND_FIRST) &&
                    (r_len_a < LW'(MAX_LEN));
        w_we_b    = w_in_acc && (i_in.data.op == OP_APPEND_SECOND) &&
                    (r_len_b < LW'(MAX_LEN));
        w_drop    = w_in_acc &&
                    (((i_in.data.op == OP_APPEND_FIRST) && !(r_len_a < LW'(MAX_LEN))) ||
                     ((i_in.data.op == OP_APPEND_SECOND) && !(r_len_b < LW'(MAX_LEN))));
        w_cs_we   = w_we_a || w_we_b;
        w_cs_sel  = w_we_b;
        w_cs_idx  = w_we_b ? r_len_b[IW-1:0] : r_len_a[IW-1:0];
        w_cs_data = CHAR_BITS'(i_in.data.ch);
    end

    // The finished distance moves into the output register once it is free; that
    // same handshake clears both strings and the overflow flag.
    assign w_cmd.start = w_in_acc && (i_in.data.op == OP_COMPUTE);
    assign w_ack       = w_stat.done && (!r_out_valid || o_out.ready);
    assign w_cmd.ack   = w_ack;

    oed_char_store #(
        .MAX_LEN   (MAX_LEN),
        .CHAR_BITS (CHAR_BITS)
    ) u_char_store (
        .i_clk    (i_clk),
        .i_we     (w_cs_we),
        .i_w_sel  (w_cs_sel),
        .i_w_idx  (w_cs_idx),
        .i_w_data (w_cs_data),
        .i_a_idx  (w_a_idx),
        .i_b_idx  (w_b_idx),
        .o_a_data (w_a_data),
        .o_b_data (w_b_data)
    );

    oed_row_store #(
        .MAX_LEN (MAX_LEN)
    ) u_row_store (
        .i_clk      (i_clk),
        .i_we       (w_row_we),
        .i_w_row    (w_w_row),
        .i_w_col    (w_w_col),
        .i_w_data   (w_w_data),
        .i_rd0_row  (w_up_row),
        .i_rd0_col  (w_up_col),
        .i_rd1_row  (w_up2_row),
        .i_rd1_col  (w_up2_col),
        .o_rd0_data (w_up_data),
        .o_rd1_data (w_up2_data)
    );

    oed_sweep #(
        .MAX_LEN   (MAX_LEN),
        .CHAR_BITS (CHAR_BITS)
    ) u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_len_a    (r_len_a),
        .i_len_b    (r_len_b),
        .o_a_idx    (w_a_idx),
        .o_b_idx    (w_b_idx),
        .i_a_data   (w_a_data),
        .i_b_data   (w_b_data),
        .o_up_row   (w_up_row),
        .o_up_col   (w_up_col),
        .o_up2_row  (w_up2_row),
        .o_up2_col  (w_up2_col),
        .i_up_data  (w_up_data),
        .i_up2_data (w_up2_data),
        .o_we       (w_row_we),
        .o_w_row    (w_w_row),
        .o_w_col    (w_w_col),
        .o_w_data   (w_w_data),
        .o_dist     (w_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ack) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (w_we_a) begin
                    r_len_a <= r_len_a + LW'(1);
                end
                if (w_we_b) begin
                    r_len_b <= r_len_b + LW'(1);
                end
                if (w_drop) begin
                    r_ovf <= 1'b1;
                end
            end
            if (w_ack) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields are cut to their port widths.
    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_word.dist_res   <= RES_W'(w_dist);
            r_out_word.len_first  <= RES_W'(r_len_a);
            r_out_word.len_second <= RES_W'(r_len_b);
            r_out_word.overflowed <= r_ovf;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= LW'(MAX_LEN)) && (r_len_b <= LW'(MAX_LEN)))
        else $error("string length beyond capacity");

    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ack |=> ((r_len_a == '0) && (r_len_b == '0) && !r_ovf))
        else $error("strings not cleared after a result");

    a_result_from_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_ack))
        else $error("result word without a finished sweep");

endmodule
